// ===== src/tcp_csm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_csm_pkg
// Shared types and codes for the TCP connection control engine.
// ----------------------------------------------------------------------------
package tcp_csm_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 4096;

  localparam logic [5:0] FLAG_MASK = 6'h3f;
  localparam logic [5:0] FLAG_FIN  = 6'h01;
  localparam logic [5:0] FLAG_SYN  = 6'h02;
  localparam logic [5:0] FLAG_RST  = 6'h04;
  localparam logic [5:0] FLAG_PSH  = 6'h08;
  localparam logic [5:0] FLAG_ACK  = 6'h10;

  typedef enum logic [2:0] {
    CMD_SEGMENT = 3'd0,
    CMD_LISTEN  = 3'd1,
    CMD_CONNECT = 3'd2,
    CMD_CLOSE   = 3'd3,
    CMD_SEND    = 3'd4,
    CMD_CONSUME = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_SYN_SENT   = 4'd2,
    ST_SYN_RCVD   = 4'd3,
    ST_ESTAB      = 4'd4,
    ST_FIN_WAIT1  = 4'd5,
    ST_FIN_WAIT2  = 4'd6,
    ST_CLOSING    = 4'd7,
    ST_TIME_WAIT  = 4'd8,
    ST_CLOSE_WAIT = 4'd9,
    ST_LAST_ACK   = 4'd10
  } tcp_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  flags;
    logic [12:0] length;
    logic [31:0] initial_seq;
  } item_t;

  typedef struct packed {
    tcp_state_t  tcp_state;
    logic [31:0] send_next;
    logic [31:0] send_unacked;
    logic [31:0] initial_send_seq;
    logic [31:0] recv_next;
    logic [31:0] initial_recv_seq;
    logic [12:0] recv_window;
  } conn_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [5:0]  flg;
    logic [12:0] win;
  } seg_t;

  typedef struct packed {
    logic        send_segment;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [5:0]  out_flags;
    logic [12:0] out_window;
    logic [3:0]  conn_state;
    logic        wake;
    logic        now_established;
    logic        data_accepted;
    logic        refused;
    logic        last;
  } result_t;

  function automatic seg_t mk_seg(logic [31:0] s, logic [31:0] a, logic [5:0] f,
                                  logic [12:0] w);
    seg_t r;
    r.seq = s;
    r.ack = a;
    r.flg = f & FLAG_MASK;
    r.win = w;
    return r;
  endfunction

endpackage

// ===== src/tcp_connection_state_machine.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_state_machine
// Control engine for one TCP connection: events in, header beats out.
// Path: an accepted event passes through the input register, then the result
//   register. Throughput: one event per cycle when it yields one beat and
//   result_ready stays high; a two-beat event holds the result port until drained.
// Reset: synchronous; clears the connection state (closed, all numbers and
//   window zero) and empties both registers.
// ----------------------------------------------------------------------------
module tcp_connection_state_machine
  import tcp_csm_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  command,
  input  logic [31:0] seq_num,
  input  logic [31:0] ack_num,
  input  logic [5:0]  flags,
  input  logic [12:0] length,
  input  logic [31:0] initial_seq,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        send_segment,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [5:0]  out_flags,
  output logic [12:0] out_window,
  output logic [3:0]  conn_state,
  output logic        wake,
  output logic        now_established,
  output logic        data_accepted,
  output logic        refused,
  output logic        last
);

  item_t   item;
  logic    item_vld;
  conn_t   conn, conn_next;
  result_t res0, res1, head;
  logic    res_two, can_push, fire;

  assign fire       = item_vld && can_push;
  assign item_ready = !item_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
      conn     <= '0;
    end else begin
      if (item_ready) item_vld <= item_valid;
      if (fire) conn <= conn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item.command     <= command;
      item.seq_num     <= seq_num;
      item.ack_num     <= ack_num;
      item.flags       <= flags;
      item.length      <= length;
      item.initial_seq <= initial_seq;
    end
  end

  tcp_csm_core #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_core (
    .item      (item),
    .conn      (conn),
    .conn_next (conn_next),
    .res0      (res0),
    .res1      (res1),
    .res_two   (res_two)
  );

  tcp_csm_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .res0     (res0),
    .res1     (res1),
    .res_two  (res_two),
    .can_push (can_push),
    .valid    (result_valid),
    .ready    (result_ready),
    .head     (head)
  );

  assign send_segment    = head.send_segment;
  assign out_seq         = head.out_seq;
  assign out_ack         = head.out_ack;
  assign out_flags       = head.out_flags;
  assign out_window      = head.out_window;
  assign conn_state      = head.conn_state;
  assign wake            = head.wake;
  assign now_established = head.now_established;
  assign data_accepted   = head.data_accepted;
  assign refused         = head.refused;
  assign last            = head.last;

  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("evaluated event produced no beat");
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_vld && !fire |=> item_vld && $stable(item))
    else $error("pending event lost");
  a_listen_refused: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == CMD_LISTEN && conn.tcp_state != ST_CLOSED
    |=> conn.tcp_state == $past(conn.tcp_state))
    else $error("refused listen changed state");
  a_conn_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(conn))
    else $error("state changed without an event");

endmodule

// ===== src/tcp_csm_core.sv =====
// ----------------------------------------------------------------------------
// tcp_csm_core
// Event evaluation: next connection state and up to two header beats.
// ----------------------------------------------------------------------------
module tcp_csm_core
  import tcp_csm_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  item_t   item,
  input  conn_t   conn,
  output conn_t   conn_next,
  output result_t res0,
  output result_t res1,
  output logic    res_two
);

  localparam logic [15:0] WinFull = 16'(WINDOW_BYTES);
  localparam logic [12:0] WinInit = WinFull[12:0];

  seg_t        segs [2];
  logic [1:0]  cnt;
  logic        f_wake, f_est, f_data, f_ref;
  logic        done;
  logic        rst_f, syn_f, ack_f, fin_f;
  logic [31:0] r_seq;
  logic [15:0] win16, total, take;
  conn_t       c;

  always_comb begin
    c      = conn;
    cnt    = 2'd0;
    segs[0] = '0;
    segs[1] = '0;
    f_wake = 1'b0;
    f_est  = 1'b0;
    f_data = 1'b0;
    f_ref  = 1'b0;
    done   = 1'b0;
    rst_f  = |(item.flags & FLAG_RST);
    syn_f  = |(item.flags & FLAG_SYN);
    ack_f  = |(item.flags & FLAG_ACK);
    fin_f  = |(item.flags & FLAG_FIN);
    r_seq  = item.seq_num + 32'(syn_f) + 32'(item.length) + 32'(fin_f);
    win16  = {3'b000, conn.recv_window};
    total  = (win16 >= WinFull) ? 16'd0 : WinFull - win16;
    take   = ({3'b000, item.length} < total) ? {3'b000, item.length} : total;

    case (item.command)
      CMD_SEGMENT: begin
        unique case (c.tcp_state)
          ST_CLOSED: begin
            done = 1'b1;
            if (!rst_f) begin
              if (ack_f) begin
                segs[cnt[0]] = mk_seg(item.ack_num, 32'd0, FLAG_RST, c.recv_window);
                cnt = cnt + 2'd1;
              end else begin
                segs[cnt[0]] = mk_seg(32'd0, r_seq, FLAG_RST, c.recv_window);
                cnt = cnt + 2'd1;
              end
            end
          end
          ST_LISTEN: begin
            done = 1'b1;
            if (!rst_f) begin
              if (ack_f) begin
                segs[cnt[0]] = mk_seg(item.ack_num, 32'd0, FLAG_RST, c.recv_window);
                cnt = cnt + 2'd1;
              end else if (syn_f) begin
                c.recv_next        = item.seq_num + 32'd1;
                c.initial_recv_seq = item.seq_num;
                c.initial_send_seq = item.initial_seq;
                c.recv_window      = WinInit;
                segs[cnt[0]] = mk_seg(c.initial_send_seq, c.recv_next,
                                      FLAG_SYN | FLAG_ACK, c.recv_window);
                cnt = cnt + 2'd1;
                c.send_next    = c.initial_send_seq + 32'd1;
                c.send_unacked = c.initial_send_seq;
                c.tcp_state    = ST_SYN_RCVD;
              end
            end
          end
          ST_SYN_SENT: begin
            done = 1'b1;
            if (ack_f && (item.ack_num <= c.initial_send_seq ||
                          item.ack_num > c.send_next)) begin
              if (!rst_f) begin
                segs[cnt[0]] = mk_seg(item.ack_num, 32'd0, FLAG_RST, c.recv_window);
                cnt = cnt + 2'd1;
              end
            end else if (!rst_f && syn_f) begin
              c.recv_next        = item.seq_num + 32'd1;
              c.initial_recv_seq = item.seq_num;
              if (ack_f) begin
                c.send_unacked = item.ack_num;
                if (c.send_unacked > c.initial_send_seq) begin
                  c.tcp_state = ST_ESTAB;
                  segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_ACK, c.recv_window);
                  cnt = cnt + 2'd1;
                  f_wake = 1'b1;
                end
              end else begin
                segs[cnt[0]] = mk_seg(c.initial_send_seq, c.recv_next, FLAG_ACK,
                                      c.recv_window);
                cnt = cnt + 2'd1;
              end
            end
          end
          default: ;
        endcase

        if (!done && item.seq_num == c.recv_next && !rst_f && !syn_f && ack_f) begin
          if (c.tcp_state == ST_LAST_ACK) begin
            f_wake = 1'b1;
            c      = '0;
          end else begin
            if (c.tcp_state == ST_SYN_RCVD) begin
              if (c.send_unacked <= item.ack_num && item.ack_num <= c.send_next) begin
                c.tcp_state = ST_ESTAB;
                f_est  = 1'b1;
                f_wake = 1'b1;
              end else if (!cnt[1]) begin
                segs[cnt[0]] = mk_seg(item.ack_num, 32'd0, FLAG_RST, c.recv_window);
                cnt = cnt + 2'd1;
              end
            end
            if (c.tcp_state inside {ST_ESTAB, ST_FIN_WAIT1, ST_FIN_WAIT2,
                                    ST_CLOSE_WAIT, ST_CLOSING}) begin
              if (c.send_unacked < item.ack_num && item.ack_num <= c.send_next) begin
                c.send_unacked = item.ack_num;
              end else if (item.ack_num > c.send_next) begin
                if (!cnt[1]) begin
                  segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_ACK, c.recv_window);
                  cnt = cnt + 2'd1;
                end
                done = 1'b1;
              end
              if (!done) begin
                if (c.tcp_state == ST_FIN_WAIT1) begin
                  if (item.ack_num == c.send_next) c.tcp_state = ST_FIN_WAIT2;
                end else if (c.tcp_state == ST_CLOSING) begin
                  if (item.ack_num == c.send_next) begin
                    c.tcp_state = ST_TIME_WAIT;
                    f_wake = 1'b1;
                  end
                  done = 1'b1;
                end
              end
            end
            if (!done) begin
              if (item.length != 13'd0 &&
                  c.tcp_state inside {ST_ESTAB, ST_FIN_WAIT1, ST_FIN_WAIT2}) begin
                c.recv_next   = item.seq_num + 32'(item.length);
                c.recv_window = (item.length >= c.recv_window) ? 13'd0 :
                                c.recv_window - item.length;
                if (!cnt[1]) begin
                  segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_ACK, c.recv_window);
                  cnt = cnt + 2'd1;
                end
                f_wake = 1'b1;
                f_data = 1'b1;
              end
              if (fin_f) begin
                c.recv_next = c.recv_next + 32'd1;
                if (!cnt[1]) begin
                  segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_ACK, c.recv_window);
                  cnt = cnt + 2'd1;
                end
                if (c.tcp_state == ST_SYN_RCVD || c.tcp_state == ST_ESTAB) begin
                  c.tcp_state = ST_CLOSE_WAIT;
                  f_wake = 1'b1;
                end else if (c.tcp_state == ST_FIN_WAIT1) begin
                  c.tcp_state = ST_FIN_WAIT2;
                end else if (c.tcp_state == ST_FIN_WAIT2) begin
                  c.tcp_state = ST_TIME_WAIT;
                  f_wake = 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_LISTEN: begin
        if (c.tcp_state == ST_CLOSED) c.tcp_state = ST_LISTEN;
        else f_ref = 1'b1;
      end
      CMD_CONNECT: begin
        if (c.tcp_state != ST_CLOSED) begin
          f_ref = 1'b1;
        end else begin
          c.recv_window      = WinInit;
          c.initial_send_seq = item.initial_seq;
          segs[cnt[0]] = mk_seg(c.initial_send_seq, 32'd0, FLAG_SYN, c.recv_window);
          cnt = cnt + 2'd1;
          c.send_next = c.initial_send_seq + 32'd1;
          c.tcp_state = ST_SYN_SENT;
        end
      end
      CMD_CLOSE: begin
        if (c.tcp_state == ST_SYN_RCVD || c.tcp_state == ST_ESTAB) begin
          segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_FIN | FLAG_ACK,
                                c.recv_window);
          cnt = cnt + 2'd1;
          c.tcp_state = ST_FIN_WAIT1;
          c.send_next = c.send_next + 32'd1;
        end else if (c.tcp_state == ST_CLOSE_WAIT) begin
          segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_FIN | FLAG_ACK,
                                c.recv_window);
          cnt = cnt + 2'd1;
          c.tcp_state = ST_LAST_ACK;
          c.send_next = c.send_next + 32'd1;
        end else begin
          c = '0;
        end
      end
      CMD_SEND: begin
        if (c.tcp_state == ST_ESTAB || c.tcp_state == ST_CLOSE_WAIT) begin
          segs[cnt[0]] = mk_seg(c.send_next, c.recv_next, FLAG_ACK | FLAG_PSH,
                                c.recv_window);
          cnt = cnt + 2'd1;
          c.send_next = c.send_next + 32'(item.length);
        end else begin
          f_ref = 1'b1;
        end
      end
      CMD_CONSUME: begin
        c.recv_window = 13'(win16 + take);
      end
      default: f_ref = 1'b1;
    endcase
    conn_next = c;
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    res0.conn_state      = conn_next.tcp_state;
    res0.wake            = f_wake;
    res0.now_established = f_est;
    res0.data_accepted   = f_data;
    res0.refused         = f_ref;
    res1 = res0;
    if (cnt != 2'd0) begin
      res0.send_segment = 1'b1;
      res0.out_seq      = segs[0].seq;
      res0.out_ack      = segs[0].ack;
      res0.out_flags    = segs[0].flg;
      res0.out_window   = segs[0].win;
    end
    res1.send_segment = 1'b1;
    res1.out_seq      = segs[1].seq;
    res1.out_ack      = segs[1].ack;
    res1.out_flags    = segs[1].flg;
    res1.out_window   = segs[1].win;
    res1.last         = 1'b1;
    res_two           = cnt[1];
    res0.last         = !cnt[1];
  end

endmodule

// ===== src/tcp_csm_outbuf.sv =====
// ----------------------------------------------------------------------------
// tcp_csm_outbuf
// Two-slot result register; loads one or two beats and drains one per cycle while ready is high.
// ----------------------------------------------------------------------------
module tcp_csm_outbuf
  import tcp_csm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t res0,
  input  result_t res1,
  input  logic    res_two,
  output logic    can_push,
  output logic    valid,
  input  logic    ready,
  output result_t head
);

  result_t    e0, e1;
  logic [1:0] cnt, cnt_next;
  logic       pop;

  assign valid = (cnt != 2'd0);
  assign pop   = valid && ready;
  assign head  = e0;

  always_comb begin
    cnt_next = cnt;
    if (pop) cnt_next = cnt - 2'd1;
    can_push = (cnt_next == 2'd0);
    if (push) cnt_next = res_two ? 2'd2 : 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      e0 <= res0;
      e1 <= res1;
    end else if (pop) begin
      e0 <= e1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("outbuf count out of range");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !e0.last && e1.last)
    else $error("first beat of a pair marked last");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd1 |-> e0.last)
    else $error("final beat not marked last");

endmodule
